// ===== hdl/vfc_pkg.sv =====
// shared types and constants for the voxel face culler
// no dependencies; used by vfc_ctrl, vfc_dpath and voxel_face_culler_core
`default_nettype none

package vfc_pkg;

   localparam int COORD_W = 5;
   localparam int EXT_W   = 7;
   localparam int THR_W   = 5;
   localparam int MASK_W  = 6;
   localparam int MAT_W   = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_WATER_TOP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRASS_TOP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRT_TOP  = 2'd2;

   localparam logic [THR_W-1:0] WATER_TOP_RST = 5'd10;
   localparam logic [THR_W-1:0] GRASS_TOP_RST = 5'd13;
   localparam logic [THR_W-1:0] DIRT_TOP_RST  = 5'd20;

   localparam logic [MAT_W-1:0] MAT_DIRT  = 2'd0;
   localparam logic [MAT_W-1:0] MAT_WATER = 2'd1;
   localparam logic [MAT_W-1:0] MAT_GRASS = 2'd2;
   localparam logic [MAT_W-1:0] MAT_SNOW  = 2'd3;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // which row of the store a read fetches
   typedef enum logic [2:0] {
      ROW_CENTER = 3'd0,
      ROW_YM     = 3'd1,
      ROW_YP     = 3'd2,
      ROW_ZM     = 3'd3,
      ROW_ZP     = 3'd4
   } vfc_row_type;

   typedef struct packed {
      logic        load_req;
      logic        clr_step;
      logic        rd_en;
      vfc_row_type rd_sel;
      logic        wr_back;
      logic        load_rsp;
   } vfc_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic rsp_free;
   } vfc_sts_type;

endpackage

`default_nettype wire

// ===== hdl/vfc_ctrl.sv =====
// sequencer for the voxel face culler: clear pass, write and query sequences
// depends on vfc_pkg
`default_nettype none

module vfc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_mode,
   output logic                      req_stall,
   output vfc_pkg::vfc_cmd_type      cmd,
   input  wire vfc_pkg::vfc_sts_type sts
);
   import vfc_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_WR_RD = 7'b0000100,
      ST_WR_WB = 7'b0001000,
      ST_Q_RD  = 7'b0010000,
      ST_Q_CAP = 7'b0100000,
      ST_Q_FIN = 7'b1000000
   } vfc_state_type;

   vfc_state_type state_ff, state_in;
   vfc_row_type   sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sel_ff   <= ROW_CENTER;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      cmd          = '0;
      cmd.rd_sel   = ROW_CENTER;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            sel_in    = ROW_CENTER;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = (req_mode == MODE_QUERY) ? ST_Q_RD : ST_WR_RD;
            end
         end
         ST_WR_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_WR_WB;
         end
         ST_WR_WB: begin
            cmd.wr_back = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_Q_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = sel_ff;
            unique case (sel_ff)
               ROW_CENTER: sel_in = ROW_YM;
               ROW_YM:     sel_in = ROW_YP;
               ROW_YP:     sel_in = ROW_ZM;
               ROW_ZM:     sel_in = ROW_ZP;
               default: begin
                  sel_in   = ROW_CENTER;
                  state_in = ST_Q_CAP;
               end
            endcase
         end
         ST_Q_CAP: begin
            state_in = ST_Q_FIN;
         end
         ST_Q_FIN: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/vfc_dpath.sv =====
// datapath of the voxel face culler: row-wide occupancy memory, neighbor
// capture, face mask and material logic, threshold registers; uses vfc_pkg
`default_nettype none

module vfc_dpath #(
   parameter int EDGE_LEN = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire vfc_pkg::vfc_cmd_type          cmd,
   output vfc_pkg::vfc_sts_type               sts,
   input  wire logic [vfc_pkg::COORD_W-1:0]   req_pos_x,
   input  wire logic [vfc_pkg::COORD_W-1:0]   req_pos_y,
   input  wire logic [vfc_pkg::COORD_W-1:0]   req_pos_z,
   input  wire logic                          req_solid_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_solid_out,
   output logic [vfc_pkg::MASK_W-1:0]         rsp_face_mask,
   output logic [vfc_pkg::MAT_W-1:0]          rsp_material,
   input  wire logic                          csr_wr_en,
   input  wire logic [vfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [vfc_pkg::THR_W-1:0]     csr_wdata
);
   import vfc_pkg::*;

   localparam int IdxW = $clog2(EDGE_LEN);
   localparam int AddrW = 2 * IdxW;
   localparam int Rows = 1 << AddrW;
   localparam logic [EXT_W-1:0] EdgeExt = EXT_W'(EDGE_LEN);
   localparam logic [EXT_W-1:0] One = EXT_W'(1);

   logic [EDGE_LEN-1:0] mem [Rows];
   logic [EDGE_LEN-1:0] rd_data_ff;
   logic [EDGE_LEN-1:0] wr_data;
   logic [AddrW-1:0]    addr;
   logic                mem_we;

   logic [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic               solid_ff;
   logic [AddrW-1:0]   clr_cnt_ff;
   logic               rd_pend_ff;
   vfc_row_type        cap_sel_ff;
   logic               c_solid_ff, xm_ff, xp_ff, ym_ff, yp_ff, zm_ff, zp_ff;
   logic [THR_W-1:0]   water_top_ff, grass_top_ff, dirt_top_ff;
   logic               rsp_valid_ff;
   logic               rsp_solid_ff;
   logic [MASK_W-1:0]  rsp_mask_ff;
   logic [MAT_W-1:0]   rsp_mat_ff;

   logic [EXT_W-1:0] x_ext, y_ext, z_ext;
   logic [EXT_W-1:0] xm_ext, xp_ext, ym_ext, yp_ext, zm_ext, zp_ext;
   logic             in_chunk, xp_in, yp_in, zp_in;
   logic [IdxW-1:0]  xi, xmi, xpi, row_y, row_z;
   logic [MAT_W-1:0] mat;
   logic [MASK_W-1:0] mask;

   assign x_ext  = EXT_W'(x_ff);
   assign y_ext  = EXT_W'(y_ff);
   assign z_ext  = EXT_W'(z_ff);
   assign xm_ext = x_ext - One;
   assign xp_ext = x_ext + One;
   assign ym_ext = y_ext - One;
   assign yp_ext = y_ext + One;
   assign zm_ext = z_ext - One;
   assign zp_ext = z_ext + One;

   assign in_chunk = (x_ext < EdgeExt) && (y_ext < EdgeExt) && (z_ext < EdgeExt);
   assign xp_in    = xp_ext < EdgeExt;
   assign yp_in    = yp_ext < EdgeExt;
   assign zp_in    = zp_ext < EdgeExt;

   assign xi  = x_ext[IdxW-1:0];
   assign xmi = xm_ext[IdxW-1:0];
   assign xpi = xp_ext[IdxW-1:0];

   // row address {z, y}
   always_comb begin
      row_y = y_ext[IdxW-1:0];
      row_z = z_ext[IdxW-1:0];
      case (cmd.rd_sel)
         ROW_YM:  row_y = ym_ext[IdxW-1:0];
         ROW_YP:  row_y = yp_ext[IdxW-1:0];
         ROW_ZM:  row_z = zm_ext[IdxW-1:0];
         ROW_ZP:  row_z = zp_ext[IdxW-1:0];
         default: ;
      endcase
      addr = cmd.clr_step ? clr_cnt_ff : {row_z, row_y};
   end

   always_comb begin
      wr_data = rd_data_ff;
      wr_data[xi] = solid_ff;
      if (cmd.clr_step) begin
         wr_data = '0;
      end
   end

   assign mem_we = cmd.clr_step || (cmd.wr_back && in_chunk);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + AddrW'(1);
         end
         rd_pend_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         x_ff     <= req_pos_x;
         y_ff     <= req_pos_y;
         z_ff     <= req_pos_z;
         solid_ff <= req_solid_in;
      end
      if (cmd.rd_en) begin
         cap_sel_ff <= cmd.rd_sel;
      end
   end

   // neighbor bits, already gated by the chunk boundary
   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         case (cap_sel_ff)
            ROW_CENTER: begin
               c_solid_ff <= in_chunk && rd_data_ff[xi];
               xm_ff      <= (x_ff != '0) && rd_data_ff[xmi];
               xp_ff      <= xp_in && rd_data_ff[xpi];
            end
            ROW_YM:  ym_ff <= (y_ff != '0) && rd_data_ff[xi];
            ROW_YP:  yp_ff <= yp_in && rd_data_ff[xi];
            ROW_ZM:  zm_ff <= (z_ff != '0) && rd_data_ff[xi];
            ROW_ZP:  zp_ff <= zp_in && rd_data_ff[xi];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         water_top_ff <= WATER_TOP_RST;
         grass_top_ff <= GRASS_TOP_RST;
         dirt_top_ff  <= DIRT_TOP_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WATER_TOP: water_top_ff <= csr_wdata;
            CSR_GRASS_TOP: grass_top_ff <= csr_wdata;
            CSR_DIRT_TOP:  dirt_top_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (y_ff <= water_top_ff) begin
         mat = MAT_WATER;
      end else if (y_ff > grass_top_ff && y_ff <= dirt_top_ff) begin
         mat = MAT_DIRT;
      end else if (y_ff > dirt_top_ff) begin
         mat = MAT_SNOW;
      end else begin
         mat = MAT_GRASS;
      end
   end

   assign mask = c_solid_ff ? ~{zp_ff, yp_ff, xp_ff, zm_ff, ym_ff, xm_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_solid_ff <= c_solid_ff;
         rsp_mask_ff  <= mask;
         rsp_mat_ff   <= mat;
      end
   end

   assign sts.clr_last = &clr_cnt_ff;
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_solid_out = rsp_solid_ff;
   assign rsp_face_mask = rsp_mask_ff;
   assign rsp_material  = rsp_mat_ff;

endmodule

`default_nettype wire

// ===== hdl/voxel_face_culler_core.sv =====
// top level of the voxel face culler: sequencer plus datapath
// depends on vfc_pkg, vfc_ctrl and vfc_dpath
//
// One bit of occupancy per voxel of an EDGE_LEN cube, kept in a single-port
// memory of rows of EDGE_LEN bits along x, one row per (y, z). After reset the
// block clears the memory one row a cycle, all 2^(2*ceil(log2 EDGE_LEN)) rows
// (1024 at EDGE_LEN 32), and takes no beat on req until that is done; csr
// writes are taken at any time. A write beat reads its row, then writes it
// back. A query beat makes five row reads (the centre row, which also
// supplies both x neighbors, and the rows at y-1, y+1, z-1, z+1) through the
// one memory port, waits for the last read data, then loads the result into
// the rsp register once rsp is free. The next req beat is taken while a
// result still waits on rsp.
`default_nettype none

module voxel_face_culler_core #(
   parameter int EDGE_LEN = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_mode,
   input  wire logic [vfc_pkg::COORD_W-1:0]   req_pos_x,
   input  wire logic [vfc_pkg::COORD_W-1:0]   req_pos_y,
   input  wire logic [vfc_pkg::COORD_W-1:0]   req_pos_z,
   input  wire logic                          req_solid_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_solid_out,
   output logic [vfc_pkg::MASK_W-1:0]         rsp_face_mask,
   output logic [vfc_pkg::MAT_W-1:0]          rsp_material,
   input  wire logic                          csr_wr_en,
   input  wire logic [vfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [vfc_pkg::THR_W-1:0]     csr_wdata
);
   import vfc_pkg::*;

   vfc_cmd_type cmd;
   vfc_sts_type sts;

   vfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   vfc_dpath #(
      .EDGE_LEN (EDGE_LEN)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .req_solid_in  (req_solid_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_solid_out (rsp_solid_out),
      .rsp_face_mask (rsp_face_mask),
      .rsp_material  (rsp_material),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

endmodule

`default_nettype wire
